// ----- rtl/local_map_window_shift_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the local map window shift block
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAP_WINDOW_SHIFT_TOP_ASSERT_SVH
`define LOCAL_MAP_WINDOW_SHIFT_TOP_ASSERT_SVH

// same-cycle implication
`define LMWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lmws_pkg.sv -----
// ----------------------------------------------------------------------------
// lmws_pkg
// Shared widths, reset values, register indexes and types of the local map
// window shift block.
// ----------------------------------------------------------------------------
package lmws_pkg;

    // default coordinate width of the stored cube
    localparam int COORD_BITS_DEF = 32;

    // fixed field widths
    localparam int SIDE_BITS  = 24;
    localparam int RANGE_BITS = 22;
    localparam int MOV_BITS   = 24;
    localparam int OUT_BITS   = 32;

    // configuration reset values
    localparam logic [SIDE_BITS-1:0]  CUBE_SIDE_RST    = 24'd200000;
    localparam logic [RANGE_BITS-1:0] DETECT_RANGE_RST = 22'd300000;

    // register index (word address bit 2)
    localparam logic REG_CUBE_SIDE    = 1'b0;
    localparam logic REG_DETECT_RANGE = 1'b1;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // floor(2^28 / 5): reciprocal for the divide by five in the move distance
    localparam int          RECIP5_SHIFT = 28;
    localparam logic [25:0] RECIP5       = 26'd53687091;

    // cycles the move distance pipeline needs after a register write
    localparam logic [1:0] MOV_SETTLE = 2'd3;

    // per-axis decision handed from an axis lane to the top level
    typedef struct packed {
        logic shift;   // a face is near: this axis moves
        logic dir_lo;  // min face near: cube moves toward lower coordinates
    } axis_ctl_t;

endpackage

// ----- rtl/lmws_mov.sv -----
// ----------------------------------------------------------------------------
// lmws_mov
// Move distance and near threshold, derived from the configuration in a
// three-stage pipeline; thr is registered in stage 1, mov in stage 3.
// ----------------------------------------------------------------------------
module lmws_mov import lmws_pkg::*; (
    input  logic                  aclk,
    input  logic [SIDE_BITS-1:0]  cube_side,
    input  logic [RANGE_BITS-1:0] detect_range,
    output logic [MOV_BITS-1:0]   thr,
    output logic [MOV_BITS-1:0]   mov
);

    logic [MOV_BITS-1:0] thr_next, thr_reg;
    logic [MOV_BITS-1:0] mov_next, mov_reg;
    logic [MOV_BITS-1:0] diff;
    logic [27:0]         diff9;
    logic [25:0]         quarter_next, quarter_reg, quarter_d_reg;
    logic [51:0]         prod;
    logic [MOV_BITS-1:0] q0_next, q0_reg, q;
    logic [26:0]         q5, rem;
    logic [MOV_BITS-1:0] half_next, half_reg, half_d_reg;
    logic                wide_next, wide_reg, wide_d_reg;

    // stage 1: thr = 3 * range (never overflows 24 bits), floor(9 * diff / 4)
    assign thr_next     = {2'b00, detect_range} + {1'b0, detect_range, 1'b0};
    assign wide_next    = cube_side > thr_next;
    assign diff         = cube_side - thr_next;
    assign diff9        = {4'b0000, diff} + {1'b0, diff, 3'b000};
    assign quarter_next = diff9[27:2];
    assign half_next    = {3'b000, detect_range[RANGE_BITS-1:1]};

    always_ff @(posedge aclk) begin
        thr_reg     <= thr_next;
        wide_reg    <= wide_next;
        quarter_reg <= quarter_next;
        half_reg    <= half_next;
    end

    // stage 2: reciprocal estimate of quarter / 5
    assign prod    = 52'(quarter_reg) * 52'(RECIP5);
    assign q0_next = prod[51:RECIP5_SHIFT];

    always_ff @(posedge aclk) begin
        q0_reg        <= q0_next;
        quarter_d_reg <= quarter_reg;
        half_d_reg    <= half_reg;
        wide_d_reg    <= wide_reg;
    end

    // stage 3: estimate is low by at most one, then the larger of the two
    assign q5       = {1'b0, q0_reg, 2'b00} + 27'(q0_reg);
    assign rem      = 27'(quarter_d_reg) - q5;
    assign q        = (rem >= 27'd5) ? q0_reg + 24'd1 : q0_reg;
    assign mov_next = (wide_d_reg && (q > half_d_reg)) ? q : half_d_reg;

    always_ff @(posedge aclk) begin
        mov_reg <= mov_next;
    end

    assign thr = thr_reg;
    assign mov = mov_reg;

endmodule

// ----- rtl/lmws_axis.sv -----
// ----------------------------------------------------------------------------
// lmws_axis
// One axis lane: near tests on both faces, placement, shifted faces and the
// removal box coordinates for that axis.
// ----------------------------------------------------------------------------
module lmws_axis import lmws_pkg::*; #(
    parameter int CB = COORD_BITS_DEF
) (
    input  logic                       cube_valid,
    input  logic signed [OUT_BITS-1:0] pos,
    input  logic signed [CB-1:0]       cmin,
    input  logic signed [CB-1:0]       cmax,
    input  logic [SIDE_BITS-1:0]       side,
    input  logic [MOV_BITS-1:0]        thr,
    input  logic [MOV_BITS-1:0]        mov,
    output axis_ctl_t                  ctl,
    output logic signed [CB-1:0]       new_min,
    output logic signed [CB-1:0]       new_max,
    output logic signed [OUT_BITS-1:0] face,
    output logic signed [OUT_BITS-1:0] base_min,
    output logic signed [OUT_BITS-1:0] base_max
);

    // working width: room for either coordinate width plus a carry and sign
    localparam int WW = ((CB > OUT_BITS) ? CB : OUT_BITS) + 2;
    localparam logic signed [WW-1:0] CB_HI  = WW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] CB_LO  = ~CB_HI;
    localparam logic signed [WW-1:0] OUT_HI = WW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] OUT_LO = ~OUT_HI;

    function automatic logic signed [CB-1:0] sat_cb(input logic signed [WW-1:0] v);
        logic signed [CB-1:0] r;
        if (v > CB_HI) begin
            r = CB_HI[CB-1:0];
        end else if (v < CB_LO) begin
            r = CB_LO[CB-1:0];
        end else begin
            r = v[CB-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [WW-1:0] v);
        logic signed [OUT_BITS-1:0] r;
        if (v > OUT_HI) begin
            r = OUT_HI[OUT_BITS-1:0];
        end else if (v < OUT_LO) begin
            r = OUT_LO[OUT_BITS-1:0];
        end else begin
            r = v[OUT_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [WW-1:0] pos_w, cmin_w, cmax_w, mov_w, side_w, half_w;
    logic signed [WW-1:0] d_lo, d_hi;
    logic [WW-1:0]        a_lo, a_hi;
    logic                 near_lo, near_hi;
    logic signed [CB-1:0] mv_min, mv_max, pl_min, pl_max;

    assign pos_w  = WW'(pos);
    assign cmin_w = WW'(cmin);
    assign cmax_w = WW'(cmax);
    assign mov_w  = $signed(WW'(mov));
    assign side_w = $signed(WW'(side));
    assign half_w = $signed(WW'(side[SIDE_BITS-1:1]));

    // near test: 2 * |pos - face| <= 3 * range
    assign d_lo    = pos_w - cmin_w;
    assign d_hi    = pos_w - cmax_w;
    assign a_lo    = d_lo[WW-1] ? WW'(-d_lo) : WW'(d_lo);
    assign a_hi    = d_hi[WW-1] ? WW'(-d_hi) : WW'(d_hi);
    assign near_lo = {a_lo, 1'b0} <= (WW+1)'(thr);
    assign near_hi = {a_hi, 1'b0} <= (WW+1)'(thr);

    // min face wins when both are near
    assign ctl.dir_lo = near_lo;
    assign ctl.shift  = near_lo | near_hi;

    // shifted faces
    assign mv_min = near_lo ? sat_cb(cmin_w - mov_w) : sat_cb(cmin_w + mov_w);
    assign mv_max = near_lo ? sat_cb(cmax_w - mov_w) : sat_cb(cmax_w + mov_w);

    // first placement around the position
    assign pl_min = sat_cb(pos_w - half_w);
    assign pl_max = sat_cb(WW'(pl_min) + side_w);

    always_comb begin
        if (!cube_valid) begin
            new_min = pl_min;
            new_max = pl_max;
        end else if (ctl.shift) begin
            new_min = mv_min;
            new_max = mv_max;
        end else begin
            new_min = cmin;
            new_max = cmax;
        end
    end

    // moved face of the vacated slab: old max - mov or old min + mov
    assign face     = sat_out(near_lo ? WW'(mv_max) : WW'(mv_min));
    assign base_min = sat_out(cmin_w);
    assign base_max = sat_out(cmax_w);

endmodule

// ----- rtl/local_map_window_shift_top.sv -----
// ----------------------------------------------------------------------------
// local_map_window_shift_top
// Sliding local map cube: emits the slabs vacated when the cube follows the
// sensor position.
// Input beats carry a sensor position (s_pos_x/y/z, signed mm); output beats
// carry one removal box each, with its axis and last_box set on the final box
// of a position. A position yields zero to three boxes; the first one after
// reset only places the cube.
// A position is registered on acceptance and evaluated once the result buffer is
// free and the move distance has settled; its boxes then enter the result buffer.
// Throughput: one position per cycle while each yields at most one box and m_ready
// is high; else the result buffer drains one box per cycle while m_ready is high,
// and one more position waits in the input register meanwhile.
// A stalled receiver holds the current box; the input register then fills and
// s_ready drops until the buffer frees.
// Reset (aresetn low, synchronous) clears the cube, drops pending beats and
// restores the registers. Configuration (APB, address 0 cube_side, 4 detect_range)
// must be written while idle (not enforced by the block); positions wait in the
// input register after a write or reset until the move distance has settled.
// ----------------------------------------------------------------------------
`include "local_map_window_shift_top_assert.svh"

module local_map_window_shift_top import lmws_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // position beats
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [OUT_BITS-1:0] s_pos_x,
    input  logic signed [OUT_BITS-1:0] s_pos_y,
    input  logic signed [OUT_BITS-1:0] s_pos_z,
    // removal box beats
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_rm_min_x,
    output logic signed [OUT_BITS-1:0] m_rm_min_y,
    output logic signed [OUT_BITS-1:0] m_rm_min_z,
    output logic signed [OUT_BITS-1:0] m_rm_max_x,
    output logic signed [OUT_BITS-1:0] m_rm_max_y,
    output logic signed [OUT_BITS-1:0] m_rm_max_z,
    output logic [1:0]                 m_shift_axis,
    output logic                       m_last_box
);

    // configuration registers
    logic [SIDE_BITS-1:0]  cube_side_reg;
    logic [RANGE_BITS-1:0] detect_range_reg;
    logic                  cfg_wr;
    logic [1:0]            cfg_wait_reg;
    logic                  cfg_busy;

    // cube state
    logic signed [COORD_BITS-1:0] cube_min_reg [3];
    logic signed [COORD_BITS-1:0] cube_max_reg [3];
    logic                         cube_valid_reg;

    // input register
    logic signed [OUT_BITS-1:0] pos_reg [3];
    logic                       in_vld_reg;

    // result buffer
    logic signed [OUT_BITS-1:0] base_min_reg [3];
    logic signed [OUT_BITS-1:0] base_max_reg [3];
    logic signed [OUT_BITS-1:0] face_reg [3];
    logic [2:0]                 lo_reg;
    logic [2:0]                 mask_reg, mask_next;

    // lane results
    axis_ctl_t                    ctl [3];
    logic signed [COORD_BITS-1:0] new_min [3];
    logic signed [COORD_BITS-1:0] new_max [3];
    logic signed [OUT_BITS-1:0]   face [3];
    logic signed [OUT_BITS-1:0]   base_min [3];
    logic signed [OUT_BITS-1:0]   base_max [3];

    logic [MOV_BITS-1:0] thr, mov;
    logic [2:0]          sel, rest, shifts;
    logic                free_next, advance;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cube_side_reg    <= CUBE_SIDE_RST;
            detect_range_reg <= DETECT_RANGE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CUBE_SIDE:    cube_side_reg    <= pwdata[SIDE_BITS-1:0];
                REG_DETECT_RANGE: detect_range_reg <= pwdata[RANGE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CUBE_SIDE:    prdata = 32'(cube_side_reg);
            REG_DETECT_RANGE: prdata = 32'(detect_range_reg);
            default:          prdata = '0;
        endcase
    end

    // hold evaluation while the move distance pipeline refills
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_wait_reg <= MOV_SETTLE;
        end else if (cfg_wr) begin
            cfg_wait_reg <= MOV_SETTLE;
        end else if (cfg_busy) begin
            cfg_wait_reg <= cfg_wait_reg - 2'd1;
        end
    end

    assign cfg_busy = cfg_wait_reg != 2'd0;

    lmws_mov u_mov (
        .aclk         (aclk),
        .cube_side    (cube_side_reg),
        .detect_range (detect_range_reg),
        .thr          (thr),
        .mov          (mov)
    );

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // lowest pending axis goes out first
    assign sel       = mask_reg & (~mask_reg + 3'd1);
    assign rest      = mask_reg & ~sel;
    assign free_next = (mask_reg == 3'b000) || ((rest == 3'b000) && m_ready);
    assign advance   = in_vld_reg && free_next && !cfg_busy;
    assign s_ready   = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
        end
    end

    // ------------------------------------------------------------------
    // Axis lanes
    // ------------------------------------------------------------------
    for (genvar i = 0; i < 3; i++) begin : g_axis
        lmws_axis #(.CB(COORD_BITS)) u_axis (
            .cube_valid (cube_valid_reg),
            .pos        (pos_reg[i]),
            .cmin       (cube_min_reg[i]),
            .cmax       (cube_max_reg[i]),
            .side       (cube_side_reg),
            .thr        (thr),
            .mov        (mov),
            .ctl        (ctl[i]),
            .new_min    (new_min[i]),
            .new_max    (new_max[i]),
            .face       (face[i]),
            .base_min   (base_min[i]),
            .base_max   (base_max[i])
        );
        assign shifts[i] = ctl[i].shift;
    end

    // ------------------------------------------------------------------
    // Cube state and result buffer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cube_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                cube_min_reg[i] <= '0;
                cube_max_reg[i] <= '0;
            end
        end else if (advance) begin
            cube_valid_reg <= 1'b1;
            for (int i = 0; i < 3; i++) begin
                cube_min_reg[i] <= new_min[i];
                cube_max_reg[i] <= new_max[i];
            end
        end
    end

    always_comb begin
        mask_next = mask_reg;
        if (advance) begin
            mask_next = cube_valid_reg ? shifts : 3'b000;
        end else if (m_valid && m_ready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 3'b000;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                base_min_reg[i] <= base_min[i];
                base_max_reg[i] <= base_max[i];
                face_reg[i]     <= face[i];
                lo_reg[i]       <= ctl[i].dir_lo;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat
    // ------------------------------------------------------------------
    assign m_valid    = mask_reg != 3'b000;
    assign m_last_box = rest == 3'b000;

    assign m_rm_min_x = (sel[0] && lo_reg[0]) ? face_reg[0] : base_min_reg[0];
    assign m_rm_min_y = (sel[1] && lo_reg[1]) ? face_reg[1] : base_min_reg[1];
    assign m_rm_min_z = (sel[2] && lo_reg[2]) ? face_reg[2] : base_min_reg[2];
    assign m_rm_max_x = (sel[0] && !lo_reg[0]) ? face_reg[0] : base_max_reg[0];
    assign m_rm_max_y = (sel[1] && !lo_reg[1]) ? face_reg[1] : base_max_reg[1];
    assign m_rm_max_z = (sel[2] && !lo_reg[2]) ? face_reg[2] : base_max_reg[2];

    always_comb begin
        case (sel)
            3'b010:  m_shift_axis = AXIS_Y;
            3'b100:  m_shift_axis = AXIS_Z;
            default: m_shift_axis = AXIS_X;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LMWS_ASSERT_NXT(a_cube_stays_placed, cube_valid_reg, cube_valid_reg,
                     "cube placement lost without reset")
    `LMWS_ASSERT_NXT(a_placement_silent, advance && !cube_valid_reg, !m_valid,
                     "first position produced a removal box")
    `LMWS_ASSERT_NXT(a_last_drains, m_valid && m_ready && m_last_box && !advance, !m_valid,
                     "result buffer not empty after last box")
    `LMWS_ASSERT_IMP(a_stall_means_full, !s_ready, in_vld_reg && (m_valid || cfg_busy),
                     "input stalled with nothing pending")

endmodule

// ----- dv/local_map_window_shift_top_test.sv -----
// ----------------------------------------------------------------------------
// local_map_window_shift_top_test
// Self-checking testbench for the sliding local map cube.
// A short table of positions (cube placement, saturated corners, near-face
// boundaries) runs first with the reset register values. Random phases follow,
// each with new cube_side / detect_range values written over APB while the
// block is idle. Every removal box is checked field by field against an
// in-bench copy of the cube that is advanced as positions are sent.
// ----------------------------------------------------------------------------
module local_map_window_shift_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lmws_pkg::*;

    localparam int     COORD_W         = COORD_BITS_DEF;
    localparam longint POS_MAX         = 64'sd2147483647;
    localparam longint POS_MIN         = -POS_MAX - 1;
    localparam longint SIDE_MAX        = (64'sd1 << SIDE_BITS) - 1;
    localparam longint RANGE_MAX       = (64'sd1 << RANGE_BITS) - 1;
    localparam int     NUM_PHASES      = 8;
    localparam int     BEATS_PER_PHASE = 60;
    localparam int     BURST_FIRST     = 200;
    localparam int     BURST_LAST      = 300;
    localparam int     SETTLE_CYCLES   = 6;
    localparam int     DRAIN_CYCLES    = 8;
    localparam int     STALL_LIMIT     = 2000;
    localparam int     MAX_REPORTS     = 10;
    localparam int     IDLE_PCT        = 11;
    localparam int     PEND_DEPTH      = 2048;

    localparam logic [2:0][1:0] AXIS_CODE = {AXIS_Z, AXIS_Y, AXIS_X};

    // how a stimulus coordinate is formed
    typedef enum logic [1:0] {AT_VALUE, FROM_MIN, FROM_MAX} ref_point_e;

    typedef struct packed {
        ref_point_e rx;
        longint     ox;
        ref_point_e ry;
        longint     oy;
        ref_point_e rz;
        longint     oz;
        bit         quiet;  // typed in: this position gives no box
    } pos_row_t;

    typedef struct packed {
        logic [2:0][OUT_BITS-1:0] rm_min;
        logic [2:0][OUT_BITS-1:0] rm_max;
        logic [1:0]               axis;
        logic                     last;
    } rm_box_t;

    // Directed positions, all with reset register values (side 200000, range
    // 300000: a face is near within 450000, the cube moves by 150000).
    localparam int NUM_DIRECTED = 17;
    localparam pos_row_t DIRECTED [NUM_DIRECTED] = '{
        // placement at the corners of the range, no box
        '{AT_VALUE, POS_MIN, AT_VALUE, 0, AT_VALUE, POS_MAX, 1'b1},
        // same point again: all min faces near, x and z saturate
        '{AT_VALUE, POS_MIN, AT_VALUE, 0, AT_VALUE, POS_MAX, 1'b0},
        // far from every face, no box
        '{AT_VALUE, POS_MAX, AT_VALUE, POS_MAX, AT_VALUE, POS_MIN, 1'b1},
        // y exactly at the near limit below the min face, then one past it
        '{AT_VALUE, POS_MAX, FROM_MIN, -450000, AT_VALUE, POS_MIN, 1'b0},
        '{AT_VALUE, POS_MAX, FROM_MIN, -450001, AT_VALUE, POS_MIN, 1'b1},
        // y exactly at the near limit above the max face, then one past it
        '{AT_VALUE, POS_MAX, FROM_MAX, 450000, AT_VALUE, POS_MIN, 1'b0},
        '{AT_VALUE, POS_MAX, FROM_MAX, 450001, AT_VALUE, POS_MIN, 1'b1},
        // inside the cube or on a face: both faces near, min face wins; other rows lie outside
        '{FROM_MIN, 50000, FROM_MIN, 100000, FROM_MAX, -1, 1'b0},
        '{FROM_MAX, 300000, FROM_MAX, 300000, FROM_MAX, 300000, 1'b0},
        '{FROM_MIN, 0, FROM_MIN, 0, FROM_MIN, 0, 1'b0},
        '{FROM_MAX, 0, FROM_MIN, 0, FROM_MAX, 0, 1'b0},
        '{AT_VALUE, 0, AT_VALUE, -1, AT_VALUE, 1, 1'b0},
        '{AT_VALUE, -1, AT_VALUE, -1, AT_VALUE, -1, 1'b0},
        '{AT_VALUE, 1431655765, AT_VALUE, -1431655766, AT_VALUE, 'h7FFF0000, 1'b0},
        '{FROM_MAX, 400000, FROM_MAX, 400000, FROM_MAX, 400000, 1'b0},
        '{FROM_MAX, 400000, FROM_MAX, 400000, FROM_MAX, 400000, 1'b0},
        '{FROM_MIN, -400000, FROM_MIN, -400000, FROM_MIN, -400000, 1'b0}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [OUT_BITS-1:0] s_pos_x;
    logic signed [OUT_BITS-1:0] s_pos_y;
    logic signed [OUT_BITS-1:0] s_pos_z;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [OUT_BITS-1:0] m_rm_min_x;
    logic signed [OUT_BITS-1:0] m_rm_min_y;
    logic signed [OUT_BITS-1:0] m_rm_min_z;
    logic signed [OUT_BITS-1:0] m_rm_max_x;
    logic signed [OUT_BITS-1:0] m_rm_max_y;
    logic signed [OUT_BITS-1:0] m_rm_max_z;
    logic [1:0]                 m_shift_axis;
    logic                       m_last_box;

    // cube tracked by the bench
    longint  side_mm;
    longint  range_mm;
    longint  cube_lo [3];
    longint  cube_hi [3];
    bit      placed;
    rm_box_t step_boxes [3];
    int      step_count;

    // expected boxes in order: written by the stimulus, read by the checker
    rm_box_t pending_mem [PEND_DEPTH];
    int      pend_wr;
    int      pend_rd;

    int      fail_count;
    int      positions_sent;
    int      boxes_checked;
    int      quiet_cycles;
    bit      burst;
    rm_box_t got_box;
    rm_box_t want_box;

    local_map_window_shift_top dut (.*);

    always #5 aclk = ~aclk;

    function automatic void log_mismatch(input string what, input longint want_v,
                                         input longint got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected %0d, got %0d", what, want_v, got_v);
    endfunction

    function automatic int pending_count();
        return pend_wr - pend_rd;
    endfunction

    function automatic longint saturate(input longint v, input int bits);
        longint hi, lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the cube by one position; the boxes it vacates go to step_boxes.
    function automatic void advance_cube(input longint px, input longint py,
                                         input longint pz);
        longint  p [3];
        longint  nlo [3];
        longint  nhi [3];
        longint  thr, mov, alt, d_lo, d_hi;
        int      dir [3];
        int      i, j;
        rm_box_t b;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        step_count = 0;

        // first position only places the cube
        if (!placed) begin
            for (i = 0; i < 3; i++) begin
                cube_lo[i] = saturate(p[i] - side_mm / 2, COORD_W);
                cube_hi[i] = saturate(cube_lo[i] + side_mm, COORD_W);
            end
            placed = 1'b1;
            return;
        end

        // move distance: larger of 0.45*(side - 3*range) and range/2
        thr = 3 * range_mm;
        mov = range_mm / 2;
        if (side_mm > thr) begin
            alt = ((side_mm - thr) * 9) / 20;
            if (alt > mov) mov = alt;
        end

        // near tests use the cube before this position; min face wins
        for (i = 0; i < 3; i++) begin
            d_lo = p[i] - cube_lo[i];
            d_hi = p[i] - cube_hi[i];
            if (d_lo < 0) d_lo = -d_lo;
            if (d_hi < 0) d_hi = -d_hi;
            dir[i] = (2 * d_lo <= thr) ? -1 : ((2 * d_hi <= thr) ? 1 : 0);
        end

        for (i = 0; i < 3; i++) begin
            nlo[i] = cube_lo[i];
            nhi[i] = cube_hi[i];
            if (dir[i] != 0) begin
                for (j = 0; j < 3; j++) begin
                    b.rm_min[j] = OUT_BITS'(saturate(cube_lo[j], OUT_BITS));
                    b.rm_max[j] = OUT_BITS'(saturate(cube_hi[j], OUT_BITS));
                end
                if (dir[i] < 0) begin
                    nlo[i] = saturate(cube_lo[i] - mov, COORD_W);
                    nhi[i] = saturate(cube_hi[i] - mov, COORD_W);
                    b.rm_min[i] = OUT_BITS'(saturate(saturate(cube_hi[i] - mov, COORD_W),
                                                     OUT_BITS));
                end else begin
                    nlo[i] = saturate(cube_lo[i] + mov, COORD_W);
                    nhi[i] = saturate(cube_hi[i] + mov, COORD_W);
                    b.rm_max[i] = OUT_BITS'(saturate(saturate(cube_lo[i] + mov, COORD_W),
                                                     OUT_BITS));
                end
                b.axis = AXIS_CODE[i];
                b.last = 1'b0;
                step_boxes[step_count] = b;
                step_count++;
            end
        end

        if (step_count > 0)
            step_boxes[step_count - 1].last = 1'b1;
        for (i = 0; i < 3; i++) begin
            cube_lo[i] = nlo[i];
            cube_hi[i] = nhi[i];
        end
    endfunction

    function automatic logic [OUT_BITS-1:0] place_coord(input ref_point_e rp,
                                                        input longint off, input int ax);
        longint v;
        case (rp)
            FROM_MIN: v = cube_lo[ax] + off;
            FROM_MAX: v = cube_hi[ax] + off;
            default:  v = off;
        endcase
        v = saturate(v, OUT_BITS);
        return v[OUT_BITS-1:0];
    endfunction

    // offset from a face: often right on the face or the near limit
    function automatic longint face_offset();
        longint h, span;
        h = (3 * range_mm) / 2;
        span = h + 4;
        case ($urandom_range(0, 11))
            0: return 0;
            1: return h;
            2: return -h;
            3: return h + 1;
            4: return -h - 1;
            default: return longint'($urandom_range(0, 32'(2 * span))) - span;
        endcase
    endfunction

    function automatic logic [OUT_BITS-1:0] random_coord(input int ax);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return place_coord($urandom_range(0, 1) ? FROM_MIN : FROM_MAX, face_offset(), ax);
        if (roll < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return place_coord(AT_VALUE, POS_MIN, ax);
            1: return place_coord(AT_VALUE, POS_MAX, ax);
            2: return place_coord(AT_VALUE, 0, ax);
            default: return place_coord(AT_VALUE, -1, ax);
        endcase
    endfunction

    // Predict the boxes of one position, then hand it to the block.
    task automatic offer_position(input logic [OUT_BITS-1:0] x, input logic [OUT_BITS-1:0] y,
                                  input logic [OUT_BITS-1:0] z, input bit quiet);
        advance_cube($signed(x), $signed(y), $signed(z));
        if (!quiet) begin
            for (int k = 0; k < step_count; k++) begin
                pending_mem[pend_wr % PEND_DEPTH] = step_boxes[k];
                pend_wr++;
            end
        end
        while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        positions_sent++;
        burst = (positions_sent >= BURST_FIRST) && (positions_sent < BURST_LAST);
    endtask

    // one APB transfer: setup, access, then idle
    task automatic apb_access(input bit wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_cube_config(input longint side_val, input longint span_val);
        logic [31:0] rb;
        apb_access(1'b1, REG_CUBE_SIDE, 32'(side_val), rb);
        apb_access(1'b1, REG_DETECT_RANGE, 32'(span_val), rb);
        side_mm  = side_val;
        range_mm = span_val;
        apb_access(1'b0, REG_CUBE_SIDE, '0, rb);
        if (rb !== 32'(side_val)) log_mismatch("cube_side readback", side_val, rb);
        apb_access(1'b0, REG_DETECT_RANGE, '0, rb);
        if (rb !== 32'(span_val)) log_mismatch("detect_range readback", span_val, rb);
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // box checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_box.rm_min = {m_rm_min_z, m_rm_min_y, m_rm_min_x};
            got_box.rm_max = {m_rm_max_z, m_rm_max_y, m_rm_max_x};
            got_box.axis   = m_shift_axis;
            got_box.last   = m_last_box;
            if (pending_count() == 0) begin
                log_mismatch("box arrived, boxes pending", 1, 0);
            end else begin
                want_box = pending_mem[pend_rd % PEND_DEPTH];
                pend_rd++;
                boxes_checked++;
                for (int j = 0; j < 3; j++) begin
                    if (got_box.rm_min[j] !== want_box.rm_min[j])
                        log_mismatch($sformatf("rm_min on axis %0d", j),
                                     $signed(want_box.rm_min[j]), $signed(got_box.rm_min[j]));
                    if (got_box.rm_max[j] !== want_box.rm_max[j])
                        log_mismatch($sformatf("rm_max on axis %0d", j),
                                     $signed(want_box.rm_max[j]), $signed(got_box.rm_max[j]));
                end
                if (got_box.axis !== want_box.axis)
                    log_mismatch("shift_axis", want_box.axis, got_box.axis);
                if (got_box.last !== want_box.last)
                    log_mismatch("last_box", want_box.last, got_box.last);
            end
        end
    end

    // watchdog: cycles in a row with no beat and no register access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_valid  = 1'b0;
        s_pos_x  = '0;
        s_pos_y  = '0;
        s_pos_z  = '0;
        m_ready  = 1'b0;
        side_mm  = CUBE_SIDE_RST;
        range_mm = DETECT_RANGE_RST;
        placed   = 1'b0;
        burst    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            cube_lo[i] = 0;
            cube_hi[i] = 0;
        end
        step_count     = 0;
        pend_wr        = 0;
        pend_rd        = 0;
        fail_count     = 0;
        positions_sent = 0;
        boxes_checked  = 0;
        quiet_cycles   = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset register values
        foreach (DIRECTED[r]) begin
            offer_position(place_coord(DIRECTED[r].rx, DIRECTED[r].ox, 0),
                           place_coord(DIRECTED[r].ry, DIRECTED[r].oy, 1),
                           place_coord(DIRECTED[r].rz, DIRECTED[r].oz, 2),
                           DIRECTED[r].quiet);
        end

        // random phases, registers rewritten while idle
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            s_valid <= 1'b0;
            while (pending_count() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            case (ph)
                0: set_cube_config(0, 0);
                1: set_cube_config(SIDE_MAX, RANGE_MAX);
                2: set_cube_config(SIDE_MAX, 0);
                3: set_cube_config(0, RANGE_MAX);
                default: set_cube_config($urandom_range(0, 32'(SIDE_MAX)),
                    longint'($urandom_range(0, 32'(RANGE_MAX))) >> $urandom_range(0, 12));
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                offer_position(random_coord(0), random_coord(1), random_coord(2), 1'b0);
        end

        // drain
        s_valid <= 1'b0;
        while (pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_count() != 0)
            log_mismatch("boxes left undelivered", 0, pending_count());

        $display("Covered %0d positions under %0d register settings, %0d removal boxes checked.",
                 positions_sent, NUM_PHASES + 1, boxes_checked);
        $display("Mismatches counted: %0d", fail_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lmws_pkg.sv
rtl/lmws_mov.sv
rtl/lmws_axis.sv
rtl/local_map_window_shift_top.sv
dv/local_map_window_shift_top_test.sv
